// ===== sv/ps2wm_pkg.sv =====
`timescale 1ns / 1ps

package ps2wm_pkg;

  localparam logic [7:0] HDR_BAD_MASK   = 8'hc0;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;
  localparam logic [7:0] WHEEL_BACK_MAX = 8'h7f;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_HDR = 1'b1;

  localparam logic [1:0] WHEEL_NONE = 2'd0;
  localparam logic [1:0] WHEEL_FWD  = 2'd1;
  localparam logic [1:0] WHEEL_BACK = 2'd2;

  localparam logic [1:0] LAST_HELD = 2'd3;

  typedef struct packed {
    logic              status;
    logic [2:0]        button_code;
    logic [1:0]        wheel_event;
    logic signed [8:0] x_motion;
    logic signed [9:0] y_motion;
  } ps2wm_result_t;

  // Left and right buttons from header bits 1:0 to the reported code.
  function automatic logic [2:0] button_map(input logic [1:0] btn);
    logic [2:0] code;
    case (btn)
      2'd0:    code = 3'd0;
      2'd1:    code = 3'd4;
      2'd2:    code = 3'd1;
      2'd3:    code = 3'd5;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/ps2_wheel_mouse_packet_decoder.sv =====
`timescale 1ns / 1ps

// Collects four-byte wheel-mouse packets from a stream of received bytes, one
// byte per beat, and gives one result beat per completed packet. A byte is
// taken in every cycle while the output register is empty or being drained,
// so the block runs at one byte per cycle; the only storage is the three held
// packet bytes, a byte count and the output register, with the whole decode
// done combinationally between them. When a packet completes with bit 7 or 6 of
// the header set, the header is dropped, the other bytes move down to form the
// next candidate packet and a result with status 1 and all other fields zero
// is given. Otherwise tuser is 0 and tdata carries the buttons, wheel and
// motion; the middle button and the sync bit are not checked.
module ps2_wheel_mouse_packet_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // button_code[2:0], wheel_event[4:3],
                                  // x_motion[13:5], y_motion[23:14]
  output logic        out_tuser   // status
);
  import ps2wm_pkg::*;

  logic [7:0]    pkt_r [3];
  logic [7:0]    pkt_nxt [3];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  ps2wm_result_t res_r, res_nxt;
  ps2wm_result_t dec_res;
  logic          hdr_bad;
  logic          in_beat;
  logic          emit;

  ps2wm_decode u_decode (
    .hdr        (pkt_r[0]),
    .x_byte     (pkt_r[1]),
    .y_byte     (pkt_r[2]),
    .wheel_byte (in_tdata),
    .hdr_bad    (hdr_bad),
    .result     (dec_res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign emit      = in_beat && (cnt_r == LAST_HELD);

  always_comb begin
    pkt_nxt = pkt_r;
    cnt_nxt = cnt_r;
    if (in_beat) begin
      if (cnt_r != LAST_HELD) begin
        pkt_nxt[cnt_r] = in_tdata;
        cnt_nxt        = 2'(cnt_r + 2'd1);
      end else if (hdr_bad) begin
        // Resync: drop the header and keep the count at three.
        pkt_nxt[0] = pkt_r[1];
        pkt_nxt[1] = pkt_r[2];
        pkt_nxt[2] = in_tdata;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      res_nxt       = dec_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.y_motion, res_r.x_motion, res_r.wheel_event,
                       res_r.button_code};

endmodule

// ===== sv/ps2wm_decode.sv =====
`timescale 1ns / 1ps

module ps2wm_decode (
  input  logic [7:0]               hdr,
  input  logic [7:0]               x_byte,
  input  logic [7:0]               y_byte,
  input  logic [7:0]               wheel_byte,
  output logic                     hdr_bad,
  output ps2wm_pkg::ps2wm_result_t result
);
  import ps2wm_pkg::*;

  logic [9:0] y_ext;

  assign hdr_bad = (hdr & HDR_BAD_MASK) != 8'h00;
  assign y_ext   = {{2{hdr[HDR_YSIGN_BIT]}}, y_byte};

  always_comb begin
    result = '0;
    if (hdr_bad) begin
      result.status = STATUS_BAD_HDR;
    end else begin
      result.status   = STATUS_OK;
      result.x_motion = {hdr[HDR_XSIGN_BIT], x_byte};
      // The mouse reports up as positive, so the vertical motion is negated.
      result.y_motion = 10'(10'd0 - y_ext);
      if (wheel_byte != 8'h00) begin
        result.wheel_event = (wheel_byte > WHEEL_BACK_MAX) ? WHEEL_FWD : WHEEL_BACK;
      end else begin
        result.button_code = button_map(hdr[1:0]);
      end
    end
  end

endmodule
